// File: hdl/armm_pkg.sv
// ----------------------------------------------------------------------------
// armm_pkg
// Types and fixed constants of the auto-ranging level mapper.
// ----------------------------------------------------------------------------
package armm_pkg;

    // Sequencer states of the mapper
    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_SPAN,
        S_FIX,
        S_PREP,
        S_SUM,
        S_ABS,
        S_DIV,
        S_FIN
    } armm_state_t;

    // Register index decoded from paddr[2]
    typedef enum logic {
        REG_INITIAL_LOW  = 1'b0,
        REG_INITIAL_HIGH = 1'b1
    } armm_reg_t;

    localparam int          MIN_SPAN      = 10;
    localparam int          LEVEL_SCALE   = 254;
    localparam int          HALF_SCALE    = 127;
    localparam int          RESET_LOW     = 0;
    localparam int          RESET_HIGH    = 1023;
    localparam logic [6:0]  LEVEL_MAX     = 7'd127;

endpackage

// File: hdl/auto_range_to_midi_mapper.sv
// ----------------------------------------------------------------------------
// auto_range_to_midi_mapper
// Tracks a running low/high bound of a raw sample and maps samples to a
// 7-bit level (action 0) or a level back to a physical value (action 1).
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------
//  item      item_valid / item_stall   action, sample, previous_level, level_in
//  result    result_valid/result_stall level_out, physical_out, kept_previous
//  config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
//  Action 0 steps through S_CMP, S_UPD, S_SPAN, S_FIX (S_SPAN, S_FIX again
//  if the minimum span is enforced), S_PREP, S_SUM, S_ABS, S_DIV, S_FIN,
//  going from S_PREP to S_FIN when the span is not positive; action 1 skips
//  S_CMP, S_UPD and S_FIX. The shared restoring divider retires one quotient
//  bit per cycle over a SAMPLE_BITS + 9 bit dividend. item_stall is high
//  while an item is at work. A finished word waits in the output register;
//  a new item is accepted meanwhile. Reset loads the bounds from the reset
//  values of the registers.
module auto_range_to_midi_mapper #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               action,
    input  logic signed [31:0] sample,
    input  logic        [6:0]  previous_level,
    input  logic        [6:0]  level_in,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic        [6:0]  level_out,
    output logic signed [31:0] physical_out,
    output logic               kept_previous,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);
    import armm_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int DW = W + 9;          // dividend magnitude / quotient width
    localparam int NW = W + 10;         // signed numerator width
    localparam int CW = $clog2(DW);

    localparam logic signed [W-1:0] SMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W:0]   SMAX_X = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0]   SMIN_X = {2'b11, {(W-1){1'b0}}};
    localparam logic signed [NW-1:0] SMAX_N = NW'(SMAX);
    localparam logic signed [NW-1:0] SMIN_N = NW'(SMIN);
    localparam logic signed [W:0]   MIN_SPAN_X = (W+1)'(MIN_SPAN);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    armm_state_t               state_reg, state_next;
    logic                      act_reg;
    logic signed [W-1:0]       samp_reg;
    logic        [6:0]         prev_reg;
    logic        [6:0]         lvl_reg;
    logic signed [W-1:0]       init_low_reg, init_high_reg;
    logic signed [W-1:0]       low_reg, high_reg;
    logic                      lt_reg, gt_reg;
    logic signed [W:0]         span_reg;
    logic signed [NW-1:0]      prod_reg, base_reg, num_reg;
    logic                      neg_reg, kept_reg;
    logic        [W:0]         rem_reg, dsr_reg;
    logic        [DW-1:0]      quo_reg;
    logic        [CW-1:0]      cnt_reg;
    logic                      result_valid_reg;
    logic        [6:0]         level_reg;
    logic signed [31:0]        phys_reg;
    logic                      keptout_reg;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                 cfg_wr;
    armm_reg_t            cfg_idx;
    logic signed [W-1:0]  wr_low, wr_high;
    logic                 item_take, result_take, fin_load;
    logic signed [W:0]    low_p10, high_m10, diff_d;
    logic signed [W-1:0]  low_p10_sat, high_m10_sat;
    logic signed [NW-1:0] dx, lx, prod_a0, prod_a1, base_a1, num_abs;
    logic        [W+1:0]  trial, trial_sub;
    logic                 trial_ge;
    logic signed [NW-1:0] q_s;
    logic signed [W-1:0]  q_sat;
    logic        [6:0]    level_fin;
    logic                 fix_needed;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = armm_reg_t'(paddr[2]);
    assign wr_low  = (cfg_idx == REG_INITIAL_LOW)  ? W'(pwdata) : init_low_reg;
    assign wr_high = (cfg_idx == REG_INITIAL_HIGH) ? W'(pwdata) : init_high_reg;

    assign pready = 1'b1;
    assign prdata = (cfg_idx == REG_INITIAL_HIGH) ? 32'(init_high_reg) : 32'(init_low_reg);

    assign item_take   = item_valid & ~item_stall;
    assign result_take = result_valid_reg & ~result_stall;

    // saturating bound moves that hold the minimum span
    assign low_p10      = (W+1)'(low_reg) + MIN_SPAN_X;
    assign high_m10     = (W+1)'(high_reg) - MIN_SPAN_X;
    assign low_p10_sat  = (low_p10 > SMAX_X) ? SMAX : W'(low_p10);
    assign high_m10_sat = (high_m10 < SMIN_X) ? SMIN : W'(high_m10);
    assign fix_needed   = (lt_reg | gt_reg) & (span_reg < MIN_SPAN_X);

    // numerator terms
    assign diff_d  = (W+1)'(samp_reg) - (W+1)'(low_reg);
    assign dx      = NW'(diff_d);
    assign lx      = NW'(low_reg);
    assign prod_a0 = (dx <<< 8) - (dx <<< 1);
    assign prod_a1 = (NW'(span_reg) * NW'($signed({1'b0, lvl_reg}))) <<< 1;
    assign base_a1 = (lx <<< 8) - (lx <<< 1) + NW'(HALF_SCALE);
    assign num_abs = num_reg[NW-1] ? -num_reg : num_reg;

    // one restoring division step
    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_ge  = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    // final result shaping
    assign q_s       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign q_sat     = (q_s > SMAX_N) ? SMAX : ((q_s < SMIN_N) ? SMIN : W'(q_s));
    assign level_fin = kept_reg ? prev_reg
                     : ((|quo_reg[DW-1:7]) ? LEVEL_MAX : quo_reg[6:0]);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = action ? S_SPAN : S_CMP;
            end
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = S_SPAN;
            S_SPAN: state_next = act_reg ? S_PREP : S_FIX;
            S_FIX:  state_next = fix_needed ? S_SPAN : S_PREP;
            S_PREP:
            begin
                if (!act_reg && span_reg <= 0)
                    state_next = S_FIN;
                else
                    state_next = S_SUM;
            end
            S_SUM:  state_next = S_ABS;
            S_ABS:  state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!result_valid_reg || !result_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        item_stall = 1'b1;
        fin_load   = 1'b0;
        case (state_reg)
            S_IDLE:  item_stall = 1'b0;
            S_FIN:   fin_load   = ~result_valid_reg | ~result_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Bounds and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_low_reg  <= W'(RESET_LOW);
            init_high_reg <= W'(RESET_HIGH);
            low_reg       <= W'(RESET_LOW);
            high_reg      <= W'(RESET_HIGH);
        end
        else if (cfg_wr)
        begin
            // either write reloads both bounds
            init_low_reg  <= wr_low;
            init_high_reg <= wr_high;
            low_reg       <= wr_low;
            high_reg      <= wr_high;
        end
        else
        begin
            case (state_reg)
                S_UPD:
                begin
                    if (lt_reg)
                        low_reg <= samp_reg;
                    else if (gt_reg)
                        high_reg <= samp_reg;
                end
                S_FIX:
                begin
                    if (fix_needed)
                    begin
                        if (lt_reg)
                            high_reg <= low_p10_sat;
                        else
                            low_reg <= high_m10_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item datapath and serial divider
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    act_reg  <= action;
                    samp_reg <= W'(sample);
                    prev_reg <= previous_level;
                    lvl_reg  <= level_in;
                    lt_reg   <= 1'b0;
                    gt_reg   <= 1'b0;
                    kept_reg <= 1'b0;
                end
            end
            S_CMP:
            begin
                lt_reg <= samp_reg < low_reg;
                gt_reg <= samp_reg > high_reg;
            end
            S_SPAN: span_reg <= (W+1)'(high_reg) - (W+1)'(low_reg);
            S_FIX:
            begin
                // span is recomputed once after a forced move
                if (fix_needed)
                begin
                    lt_reg <= 1'b0;
                    gt_reg <= 1'b0;
                end
            end
            S_PREP:
            begin
                if (act_reg)
                begin
                    prod_reg <= prod_a1;
                    base_reg <= base_a1;
                end
                else
                begin
                    kept_reg <= span_reg <= 0;
                    prod_reg <= prod_a0;
                    base_reg <= NW'(span_reg);
                end
            end
            S_SUM: num_reg <= prod_reg + base_reg;
            S_ABS:
            begin
                neg_reg <= num_reg[NW-1];
                quo_reg <= DW'(num_abs);
                rem_reg <= '0;
                dsr_reg <= act_reg ? (W+1)'(LEVEL_SCALE) : {span_reg[W-1:0], 1'b0};
                cnt_reg <= CW'(DW - 1);
            end
            S_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub[W:0] : trial[W:0];
                quo_reg <= {quo_reg[DW-2:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (fin_load)
            result_valid_reg <= 1'b1;
        else if (result_take)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            if (act_reg)
            begin
                level_reg   <= '0;
                phys_reg    <= 32'(q_sat);
                keptout_reg <= 1'b0;
            end
            else
            begin
                level_reg   <= level_fin;
                phys_reg    <= '0;
                keptout_reg <= kept_reg;
            end
        end
    end

    assign result_valid  = result_valid_reg;
    assign level_out     = level_reg;
    assign physical_out  = phys_reg;
    assign kept_previous = keptout_reg;

`ifndef SYNTH
    // a word carries either a level or a physical value, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && physical_out != 0 |-> level_out == 0 && !kept_previous)
        else $error("result word carries both a level and a physical value");

    // after widening, the bounds are ordered and the sample is not below the low bound
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PREP && !act_reg |-> high_reg >= low_reg && samp_reg >= low_reg)
        else $error("bounds out of order after widening");

    // the divider ends after its last step
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == '0 |=> state_reg == S_FIN)
        else $error("divider did not finish");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the auto-ranging level mapper. Items go in and results come out
// under random valid/stall gaps, and the bound registers are rewritten between
// phases. A tracker class keeps its own copy of the running bounds and
// predicts each result word. Each word leaving the block is compared with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;
    import armm_pkg::*;

    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;
    localparam longint SPAN_FLOOR = 10;
    localparam longint STEPS      = 254;
    localparam longint TOP_LEVEL  = 127;
    localparam int     IDLE_PCT   = 17;
    localparam int     HOLDOFF    = 300;
    localparam int     CYCLE_CAP  = 300000;

    typedef struct {
        logic [6:0]         level;
        logic signed [31:0] phys;
        logic               kept;
    } level_word_t;

    class auto_range_tracker;
        longint      start_lo;
        longint      start_hi;
        longint      lo;
        longint      hi;
        level_word_t due[$];
        int          fails;

        function new();
            start_lo = 0;
            start_hi = 1023;
            lo       = start_lo;
            hi       = start_hi;
            fails    = 0;
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_MAX)
                return WORD_MAX;
            if (v < WORD_MIN)
                return WORD_MIN;
            return v;
        endfunction

        // writing either bound reloads both running bounds
        function void load_bound(armm_reg_t r, logic signed [31:0] val);
            if (r == REG_INITIAL_LOW)
                start_lo = val;
            else
                start_hi = val;
            lo = start_lo;
            hi = start_hi;
        endfunction

        function void take_reading(logic act, logic signed [31:0] smp, logic [6:0] prev,
                                   logic [6:0] lvl);
            longint      v;
            longint      span;
            longint      q;
            level_word_t w;
            w.level = '0;
            w.phys  = '0;
            w.kept  = 1'b0;
            if (act == 1'b0)
            begin
                v = smp;
                // widen the range, holding the span at the floor where possible
                if (v < lo)
                begin
                    lo = v;
                    if (hi - lo < SPAN_FLOOR)
                        hi = clamp_word(lo + SPAN_FLOOR);
                end
                else if (v > hi)
                begin
                    hi = v;
                    if (hi - lo < SPAN_FLOOR)
                        lo = clamp_word(hi - SPAN_FLOOR);
                end
                span = hi - lo;
                if (span <= 0)
                begin
                    w.level = prev;
                    w.kept  = 1'b1;
                end
                else
                begin
                    q = (STEPS * (v - lo) + span) / (2 * span);
                    w.level = (q > TOP_LEVEL) ? 7'(TOP_LEVEL) : 7'(q);
                end
            end
            else
            begin
                span = hi - lo;
                // division truncates toward zero, as the block does
                q = (STEPS * lo + 2 * longint'(lvl) * span + TOP_LEVEL) / STEPS;
                w.phys = 32'(clamp_word(q));
            end
            due.push_back(w);
        endfunction

        function void match_word(logic [6:0] level, logic signed [31:0] phys, logic kept);
            level_word_t w;
            if (due.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: level %0d phys %0d kept %0b", level, phys, kept);
                return;
            end
            w = due.pop_front();
            if (level !== w.level || phys !== w.phys || kept !== w.kept)
            begin
                fails++;
                if (fails <= 10)
                    $display({"word mismatch: expected level %0d phys %0d kept %0b, ",
                              "got level %0d phys %0d kept %0b"},
                             w.level, w.phys, w.kept, level, phys, kept);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic               action = 1'b0;
    logic signed [31:0] sample = '0;
    logic        [6:0]  previous_level = '0;
    logic        [6:0]  level_in = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic        [6:0]  level_out;
    logic signed [31:0] physical_out;
    logic               kept_previous;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic        [2:0]  paddr = '0;
    logic        [31:0] pwdata = '0;
    logic        [31:0] prdata;
    logic               pready;

    bit steady = 1'b0;
    int holdoffs_asked = 0;
    int holdoffs_done = 0;
    int holdoff_left = 0;

    auto_range_tracker tracker = new();

    auto_range_to_midi_mapper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .sample         (sample),
        .previous_level (previous_level),
        .level_in       (level_in),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .level_out      (level_out),
        .physical_out   (physical_out),
        .kept_previous  (kept_previous),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stall, long hold-off on request, none while steady
    always @(negedge clk)
    begin
        if (holdoffs_asked != holdoffs_done)
        begin
            holdoff_left = HOLDOFF;
            holdoffs_done++;
        end
        if (holdoff_left > 0)
        begin
            result_stall = 1'b1;
            holdoff_left--;
        end
        else if (steady)
            result_stall = 1'b0;
        else
            result_stall = ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.match_word(level_out, physical_out, kept_previous);
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(logic act, logic [31:0] smp, logic [6:0] prev, logic [6:0] lvl);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid     = 1'b1;
        action         = act;
        sample         = smp;
        previous_level = prev;
        level_in       = lvl;
        do
            @(posedge clk);
        while (item_stall);
        tracker.take_reading(act, smp, prev, lvl);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain();
        item_valid = 1'b0;
        while (tracker.due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_bound(armm_reg_t r, logic [31:0] val);
        paddr   = {r, 2'b00};
        pwdata  = val;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        tracker.load_bound(r, val);
    endtask

    task automatic set_bounds(logic [31:0] low, logic [31:0] high);
        drain();
        write_bound(REG_INITIAL_LOW, low);
        write_bound(REG_INITIAL_HIGH, high);
    endtask

    task automatic run_random(int n);
        longint      a;
        longint      b;
        longint      off;
        logic [31:0] smp;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            a = (tracker.lo < tracker.hi) ? tracker.lo : tracker.hi;
            b = (tracker.lo < tracker.hi) ? tracker.hi : tracker.lo;
            if (pick < 60)
            begin
                off = longint'($urandom) % (b - a + 1);
                smp = 32'(a + off);
            end
            else if (pick < 85)
            begin
                off = longint'($urandom_range(40)) - 20;
                smp = 32'(((pick < 72) ? tracker.lo : tracker.hi) + off);
            end
            else if (pick < 93)
            begin
                case ($urandom_range(3))
                    0: smp = 32'h8000_0000;
                    1: smp = 32'h7fff_ffff;
                    2: smp = 32'h0000_0000;
                    default: smp = 32'hffff_ffff;
                endcase
            end
            else
                smp = $urandom;
            send_item(1'($urandom_range(1)), smp, 7'($urandom_range(127)),
                      7'($urandom_range(127)));
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset bounds 0..1023: both directions, rounding, widening both ways
        send_item(1'b1, 32'd0, 7'd0, 7'd0);
        send_item(1'b1, 32'd0, 7'd0, 7'd127);
        send_item(1'b1, 32'd0, 7'd0, 7'd64);
        send_item(1'b0, 32'd0, 7'd0, 7'd0);
        send_item(1'b0, 32'd1023, 7'd127, 7'd0);
        send_item(1'b0, 32'd4, 7'd0, 7'd0);
        send_item(1'b0, 32'd2000, 7'd0, 7'd0);
        send_item(1'b0, -32'sd500, 7'd0, 7'd0);

        // zero span: previous level comes back flagged
        set_bounds(32'd500, 32'd500);
        send_item(1'b0, 32'd500, 7'd127, 7'd0);
        send_item(1'b1, 32'd0, 7'd0, 7'd127);

        // bounds crossed by configuration
        set_bounds(32'd1000, -32'sd1000);
        send_item(1'b1, 32'd0, 7'd0, 7'd127);
        send_item(1'b1, 32'd0, 7'd0, 7'd1);
        send_item(1'b0, 32'd0, 7'd0, 7'd0);

        // widening at the top of the range saturates the high bound
        set_bounds(32'h7fff_ffff, 32'h7fff_ffff);
        send_item(1'b0, 32'h7fff_ffff, 7'd85, 7'd0);
        send_item(1'b0, 32'h7fff_fffd, 7'd0, 7'd0);
        send_item(1'b1, 32'd0, 7'd0, 7'd127);

        // widening at the bottom saturates the low bound, then full range
        set_bounds(32'h8000_0000, 32'h8000_0000);
        send_item(1'b0, 32'h8000_0003, 7'd0, 7'd0);
        send_item(1'b0, 32'h7fff_ffff, 7'd0, 7'd0);
        send_item(1'b0, 32'h8000_0000, 7'd0, 7'd0);
        send_item(1'b0, 32'd0, 7'd0, 7'd0);
        send_item(1'b1, 32'd0, 7'd0, 7'd127);
        send_item(1'b1, 32'd0, 7'd0, 7'd0);

        // default range; the receiver holds off while items keep coming
        set_bounds(32'd0, 32'd1023);
        run_random(30);
        holdoffs_asked++;
        run_random(40);
        drain();
        run_random(30);

        // full range with no idling on either side
        set_bounds(32'h8000_0000, 32'h7fff_ffff);
        steady = 1'b1;
        run_random(80);
        drain();
        steady = 1'b0;

        // crossed bounds
        set_bounds($urandom_range(32'h7fff_ffff, 1), 32'(0 - $urandom_range(100000)));
        run_random(100);

        // random narrow range
        pwdata = $urandom;
        set_bounds(pwdata, pwdata + $urandom_range(2000));
        run_random(100);

        drain();
        repeat (60) @(posedge clk);
        if (tracker.fails == 0 && tracker.due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
